>>> rtl/core/hsvrgb_pkg.sv
package hsvrgb_pkg;

	// field widths
	localparam int unsigned HueW   = 9;
	localparam int unsigned PctW   = 7;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned FracW  = 6;

	// colour constants
	localparam int unsigned HueSectorDeg = 60;
	localparam int unsigned PercentFull  = 100;
	localparam int unsigned ByteFull     = 255;
	localparam int unsigned SectorCount  = 6;
	localparam int unsigned Span         = HueSectorDeg * PercentFull;

	// number of sector boundaries below the largest 9-bit hue
	localparam int unsigned HueSteps = ((1 << HueW) - 1) / HueSectorDeg;
	localparam int unsigned QuotW    = 4;

	// internal arithmetic widths
	localparam int unsigned ScaleW = 15; // 255 * value
	localparam int unsigned DiffW  = 13; // 6000 - k * sat
	localparam int unsigned NumW   = ScaleW + DiffW;

	// divide by 600000 = 2^6 * 9375: shift, then multiply by a rounded-up reciprocal
	localparam int unsigned Divisor    = Span * PercentFull;
	localparam int unsigned PreShift   = 6;
	localparam int unsigned DivOdd     = Divisor >> PreShift;
	localparam int unsigned RecipShift = 36;
	localparam int unsigned RecipW     = 23;
	localparam logic [63:0] RecipMul   =
		((64'd1 << RecipShift) + 64'(DivOdd) - 64'd1) / 64'(DivOdd);
	localparam int unsigned QuoInW     = NumW - PreShift;
	localparam int unsigned ProdW      = QuoInW + RecipW;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW  = 3'd0,
		SEC_YELLOW_GRN  = 3'd1,
		SEC_GRN_CYAN    = 3'd2,
		SEC_CYAN_BLUE   = 3'd3,
		SEC_BLUE_MAG    = 3'd4,
		SEC_MAG_RED     = 3'd5
	} sector_t;

endpackage

>>> rtl/core/hsvrgb_level.sv
module hsvrgb_level
	import hsvrgb_pkg::*;
(
	input  logic              clk,
	input  logic              adv,
	input  logic [FracW-1:0]  k,
	input  logic [PctW-1:0]   sat,
	input  logic [PctW-1:0]   val,
	output logic [ByteW-1:0]  level
);

	logic [ScaleW-1:0] scale_s2;
	logic [DiffW-1:0]  diff_s2;
	logic [NumW-1:0]   num_s3;
	logic [ByteW-1:0]  level_s4;
	logic [DiffW-1:0]  ks;
	logic [ProdW-1:0]  prod;

	// k * sat never exceeds 6000
	assign ks = DiffW'(k) * DiffW'(sat);

	always_ff @(posedge clk) begin
		if (adv) begin
			scale_s2 <= ScaleW'(ByteFull) * ScaleW'(val);
			diff_s2  <= DiffW'(Span) - ks;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3 <= NumW'(scale_s2) * NumW'(diff_s2);
		end
	end

	// exact floor of num / 600000
	assign prod = ProdW'(num_s3[NumW-1:PreShift]) * ProdW'(RecipMul[RecipW-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s4 <= prod[RecipShift +: ByteW];
		end
	end

	assign level = level_s4;

endmodule

>>> rtl/core/hsv_to_rgb_converter.sv
// hsv to rgb colour converter, one colour per item
//
// source channel: src_valid / src_stall with hue (degrees), saturation and
// brightness (percent) and alpha_in. destination channel: dst_valid /
// dst_stall with red, green, blue and alpha_out. an item moves on a rising
// edge where valid is high and stall is low.
//
// an item passes in order through the registers for clamp/sector, k*sat,
// 255*v*(6000-k*sat), reciprocal multiply and channel select, one stage each.
// the pipeline takes one item every cycle while dst_stall does not hold the output.
//
// while dst_valid is high and dst_stall is high, every stage holds and
// src_stall is raised, so nothing is lost or repeated. empty stages do not
// close up during a stall.
//
// zero saturation gives a grey pixel with alpha_out forced to 255. hue of 360
// or more wraps, saturation and brightness above 100 clamp to 100.
// arst_n clears all valid bits; data registers are not reset.
module hsv_to_rgb_converter
	import hsvrgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  logic [HueW-1:0]   hue,
	input  logic [PctW-1:0]   saturation,
	input  logic [PctW-1:0]   brightness,
	input  logic [ByteW-1:0]  alpha_in,
	output logic              dst_valid,
	input  logic              dst_stall,
	output logic [ByteW-1:0]  red,
	output logic [ByteW-1:0]  green,
	output logic [ByteW-1:0]  blue,
	output logic [ByteW-1:0]  alpha_out
);

	// whole pipeline moves together unless the output item is held
	logic adv;
	assign adv       = !(dst_valid && dst_stall);
	assign src_stall = !adv;

	// stage 1: clamp, sector and fraction of the hue
	logic [QuotW-1:0] quot;
	logic [HueW-1:0]  hue_base;
	logic [PctW-1:0]  sat_c;
	logic [PctW-1:0]  val_c;
	sector_t          sector_c;

	always_comb begin
		quot = '0;
		for (int i = 1; i <= HueSteps; i++) begin
			if (hue >= HueW'(i * HueSectorDeg)) begin
				quot = quot + QuotW'(1);
			end
		end
		hue_base = HueW'(quot) * HueW'(HueSectorDeg);
		// quotient is at most 8, so one conditional subtract wraps it
		if (quot >= QuotW'(SectorCount)) begin
			sector_c = sector_t'(3'(quot - QuotW'(SectorCount)));
		end else begin
			sector_c = sector_t'(3'(quot));
		end
		sat_c = (saturation > PctW'(PercentFull)) ? PctW'(PercentFull) : saturation;
		val_c = (brightness > PctW'(PercentFull)) ? PctW'(PercentFull) : brightness;
	end

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [FracW-1:0] frac_s1;
	logic [PctW-1:0]  sat_s1, val_s1;
	sector_t          sector_s1, sector_s2, sector_s3, sector_s4;
	logic             grey_s1, grey_s2, grey_s3, grey_s4, grey_s5;
	logic [ByteW-1:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			dst_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= src_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			dst_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_s1   <= FracW'(hue - hue_base);
			sat_s1    <= sat_c;
			val_s1    <= val_c;
			sector_s1 <= sector_c;
			grey_s1   <= (sat_c == '0);
			alpha_s1  <= alpha_in;
			// sidebands follow the arithmetic in the level units
			sector_s2 <= sector_s1;
			sector_s3 <= sector_s2;
			sector_s4 <= sector_s3;
			grey_s2   <= grey_s1;
			grey_s3   <= grey_s2;
			grey_s4   <= grey_s3;
			alpha_s2  <= alpha_s1;
			alpha_s3  <= alpha_s2;
			alpha_s4  <= alpha_s3;
		end
	end

	// stages 2..4: the four candidate levels v, p, q and t
	logic [FracW-1:0] k_t;
	logic [ByteW-1:0] lv, lp, lq, lt;

	assign k_t = FracW'(HueSectorDeg) - frac_s1;

	hsvrgb_level u_lv (
		.clk   (clk),
		.adv   (adv),
		.k     ('0),
		.sat   (sat_s1),
		.val   (val_s1),
		.level (lv)
	);

	hsvrgb_level u_lp (
		.clk   (clk),
		.adv   (adv),
		.k     (FracW'(HueSectorDeg)),
		.sat   (sat_s1),
		.val   (val_s1),
		.level (lp)
	);

	hsvrgb_level u_lq (
		.clk   (clk),
		.adv   (adv),
		.k     (frac_s1),
		.sat   (sat_s1),
		.val   (val_s1),
		.level (lq)
	);

	hsvrgb_level u_lt (
		.clk   (clk),
		.adv   (adv),
		.k     (k_t),
		.sat   (sat_s1),
		.val   (val_s1),
		.level (lt)
	);

	// stage 5: route the levels to the channels by sector
	logic [ByteW-1:0] r_c, g_c, b_c;

	always_comb begin
		if (grey_s4) begin
			r_c = lv;
			g_c = lv;
			b_c = lv;
		end else begin
			case (sector_s4)
				SEC_RED_YELLOW: begin
					r_c = lv; g_c = lt; b_c = lp;
				end
				SEC_YELLOW_GRN: begin
					r_c = lq; g_c = lv; b_c = lp;
				end
				SEC_GRN_CYAN: begin
					r_c = lp; g_c = lv; b_c = lt;
				end
				SEC_CYAN_BLUE: begin
					r_c = lp; g_c = lq; b_c = lv;
				end
				SEC_BLUE_MAG: begin
					r_c = lt; g_c = lp; b_c = lv;
				end
				default: begin
					r_c = lv; g_c = lp; b_c = lq;
				end
			endcase
		end
	end

	logic [ByteW-1:0] red_s5, green_s5, blue_s5, alpha_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s5   <= r_c;
			green_s5 <= g_c;
			blue_s5  <= b_c;
			alpha_s5 <= grey_s4 ? ByteW'(ByteFull) : alpha_s4;
			grey_s5  <= grey_s4;
		end
	end

	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;
	assign alpha_out = alpha_s5;

	// a grey item leaves with equal channels and opaque alpha
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && grey_s5 |->
			red == green && green == blue && alpha_out == ByteW'(ByteFull))
		else $error("grey item left with unequal channels or alpha");

	// a held output freezes every valid bit behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> $stable({v_s1, v_s2, v_s3, v_s4}) && dst_valid)
		else $error("pipeline moved during output stall");

	// an item in the last level stage reaches the output on the next move
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && adv |=> dst_valid)
		else $error("item dropped between level stage and output");

	// for every output item, some channel holds the maximum level of the three
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |->
			(red >= green && red >= blue) || (green >= red && green >= blue) ||
			(blue >= red && blue >= green))
		else $error("no channel holds the maximum level");

endmodule
